// ===== design/dctd_pkg.sv =====
// Shared types and constants for the dial count to tap divider.
`timescale 1ns / 1ps

package dctd_pkg;

   localparam int COUNT_W    = 16;
   localparam int REM_W      = 48;
   localparam int PARAM_W    = 32;
   localparam int HOLD_W     = 16;
   localparam int CPR_W      = 16;
   localparam int TPR_W      = 9;
   localparam int SLOT_MAX_W = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = COUNT_W + TPR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_REV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGERS_PER_ROT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME = 2'd2;

   localparam logic [CPR_W-1:0]  CPR_RESET  = 16'd4096;
   localparam logic [TPR_W-1:0]  TPR_RESET  = 9'd20;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd30;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_CW   = 2'd1;
   localparam logic [1:0] DIR_CCW  = 2'd2;

   localparam logic STATUS_TRANSPARENT = 1'b0;
   localparam logic STATUS_OPAQUE      = 1'b1;

   localparam logic KIND_STORE   = 1'b0;
   localparam logic KIND_PROCESS = 1'b1;

   localparam logic signed [REM_W-1:0] REM_MAX = {1'b0, {(REM_W-1){1'b1}}};
   localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

   typedef struct packed {
      logic [CPR_W-1:0]  rev_counts;
      logic [TPR_W-1:0]  taps_per_rev;
      logic [HOLD_W-1:0] hold_time_ms;
   } cfg_type;

   typedef struct packed {
      logic                        transparent;
      logic signed [COUNT_W-1:0]   counts;
      logic [SLOT_MAX_W-1:0]       slot;
      logic [PARAM_W-1:0]          cw_param;
      logic [PARAM_W-1:0]          ccw_param;
   } queue_entry_type;

   typedef struct packed {
      logic                  active;
      logic [SLOT_MAX_W-1:0] addr;
   } clear_type;

   typedef struct packed {
      logic [1:0]         direction;
      logic [PARAM_W-1:0] key_param;
      logic               is_press;
      logic [HOLD_W-1:0]  hold_ms;
      logic               status;
      logic               last;
   } result_type;

   typedef enum logic [1:0] {
      F_CLEAR,
      F_IDLE,
      F_LOOKUP
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_READ,
      B_MUL,
      B_ADD,
      B_ABS,
      B_DIV,
      B_FIX,
      B_WB,
      B_EMIT
   } back_state_type;

endpackage

// ===== design/dctd_ram.sv =====
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps

module dctd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dctd_queue.sv =====
// Two entry queue that carries classified process items from the front to the back.
`timescale 1ns / 1ps

module dctd_queue
   import dctd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type pop_entry,
   output logic            full,
   output logic            empty
);

   queue_entry_type entries_ff [2];
   logic            wr_ptr_ff;
   logic            wr_ptr_in;
   logic            rd_ptr_ff;
   logic            rd_ptr_in;
   logic [1:0]      count_ff;
   logic [1:0]      count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = entries_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);

endmodule

// ===== design/dctd_front.sv =====
// Front part: takes input beats, keeps the pending counts and classifies process items.
`timescale 1ns / 1ps

module dctd_front
   import dctd_pkg::*;
#(
   parameter int SENSORS = 4,
   parameter int LAYERS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [1:0]                req_sensor_index,
   input  logic [2:0]                req_layer_index,
   input  logic signed [COUNT_W-1:0] req_dial_counts,
   input  logic                      req_trigger_mode,
   input  logic [PARAM_W-1:0]        req_cw_param,
   input  logic [PARAM_W-1:0]        req_ccw_param,
   input  logic                      queue_full,
   output logic                      push,
   output queue_entry_type           push_entry,
   output clear_type                 clear
);

   localparam int SLOTS  = SENSORS * LAYERS;
   localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

   front_state_type             state_ff;
   front_state_type             state_in;
   logic [SLOT_W-1:0]           clr_ff;
   logic [SLOT_W-1:0]           clr_in;
   logic [SLOT_W-1:0]           slot_ff;
   logic                        valid_ff;
   logic                        trig_ff;
   logic [PARAM_W-1:0]          cwp_ff;
   logic [PARAM_W-1:0]          ccwp_ff;
   logic                        accept;
   logic                        in_range;
   logic [SLOT_W-1:0]           req_slot;
   logic                        wr_en;
   logic [SLOT_W-1:0]           wr_addr;
   logic [COUNT_W-1:0]          wr_data;
   logic [SLOT_W-1:0]           rd_addr;
   logic [COUNT_W-1:0]          rd_data;
   logic signed [COUNT_W-1:0]   counts;

   assign in_range = (32'(req_sensor_index) < SENSORS) && (32'(req_layer_index) < LAYERS);
   assign req_slot = in_range ?
                     SLOT_W'(32'(req_sensor_index) * LAYERS + 32'(req_layer_index)) : '0;
   assign accept   = req_valid && !req_stall;
   assign counts   = valid_ff ? $signed(rd_data) : '0;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      req_stall  = 1'b1;
      wr_en      = 1'b0;
      wr_addr    = req_slot;
      wr_data    = req_dial_counts;
      rd_addr    = slot_ff;
      push       = 1'b0;
      push_entry.transparent = !trig_ff || (counts == '0);
      push_entry.counts      = counts;
      push_entry.slot        = SLOT_MAX_W'(slot_ff);
      push_entry.cw_param    = cwp_ff;
      push_entry.ccw_param   = ccwp_ff;
      case (state_ff)
         F_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = F_IDLE;
            end
         end
         F_IDLE: begin
            req_stall = queue_full;
            rd_addr   = req_slot;
            if (accept) begin
               if (req_kind == KIND_STORE) begin
                  wr_en = in_range;
               end else begin
                  state_in = F_LOOKUP;
               end
            end
         end
         F_LOOKUP: begin
            if (!queue_full) begin
               push     = 1'b1;
               wr_en    = valid_ff;
               wr_addr  = slot_ff;
               wr_data  = '0;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_kind == KIND_PROCESS) begin
         slot_ff  <= req_slot;
         valid_ff <= in_range;
         trig_ff  <= req_trigger_mode;
         cwp_ff   <= req_cw_param;
         ccwp_ff  <= req_ccw_param;
      end
   end

   assign clear.active = (state_ff == F_CLEAR);
   assign clear.addr   = SLOT_MAX_W'(clr_ff);

   dctd_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(SLOTS)
   ) u_pending_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== design/dctd_back.sv =====
// Back part: accumulates the remainder, divides, caps the taps and emits the result beats.
`timescale 1ns / 1ps

module dctd_back
   import dctd_pkg::*;
#(
   parameter int SENSORS  = 4,
   parameter int LAYERS   = 8,
   parameter int MAX_TAPS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  clear_type       clear,
   input  logic            queue_empty,
   input  queue_entry_type pop_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output result_type      rsp_result
);

   localparam int SLOTS  = SENSORS * LAYERS;
   localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam int TAP_W  = $clog2(MAX_TAPS + 1);
   localparam int CAP_W  = CPR_W + TAP_W;
   localparam int CNT_W  = $clog2(REM_W);

   back_state_type              state_ff;
   back_state_type              state_in;
   logic                        single_ff;
   logic                        single_status_ff;
   logic signed [COUNT_W-1:0]   counts_ff;
   logic [SLOT_W-1:0]           slot_ff;
   logic [PARAM_W-1:0]          cwp_ff;
   logic [PARAM_W-1:0]          ccwp_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [REM_W-1:0]     rem_ff;
   logic [CPR_W-1:0]            divisor_ff;
   logic [CAP_W-1:0]            capprod_ff;
   logic signed [REM_W-1:0]     sat_ff;
   logic                        neg_ff;
   logic [REM_W-1:0]            mag_ff;
   logic [REM_W-1:0]            div_q_ff;
   logic [CPR_W-1:0]            div_r_ff;
   logic [CNT_W-1:0]            div_cnt_ff;
   logic [REM_W-1:0]            rem_mag_ff;
   logic [TAP_W-1:0]            taps_ff;
   logic                        press_ff;
   logic                        rsp_valid_ff;
   result_type                  rsp_result_ff;

   logic [REM_W:0]              sum_wide;
   logic [CPR_W:0]              trial;
   logic                        trial_ge;
   logic                        capped;
   logic                        out_free;
   logic                        load_out;
   result_type                  next_result;
   logic                        wr_en;
   logic [SLOT_W-1:0]           wr_addr;
   logic [REM_W-1:0]            wr_data;
   logic [REM_W-1:0]            rd_data;

   assign sum_wide = {rem_ff[REM_W-1], rem_ff} +
                     {{(REM_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign trial    = {div_r_ff, div_q_ff[REM_W-1]};
   assign trial_ge = trial >= {1'b0, divisor_ff};
   assign capped   = div_q_ff > REM_W'(MAX_TAPS);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      pop         = 1'b0;
      load_out    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = neg_ff ? (~rem_mag_ff + REM_W'(1)) : rem_mag_ff;
      next_result.direction = neg_ff ? DIR_CCW : DIR_CW;
      next_result.key_param = neg_ff ? ccwp_ff : cwp_ff;
      next_result.is_press  = press_ff;
      next_result.hold_ms   = press_ff ? cfg.hold_time_ms : '0;
      next_result.status    = STATUS_OPAQUE;
      next_result.last      = !press_ff && (taps_ff == TAP_W'(1));
      if (single_ff) begin
         next_result.direction = DIR_NONE;
         next_result.key_param = '0;
         next_result.is_press  = 1'b0;
         next_result.hold_ms   = '0;
         next_result.status    = single_status_ff;
         next_result.last      = 1'b1;
      end
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty && !clear.active) begin
               pop      = 1'b1;
               state_in = pop_entry.transparent ? B_EMIT : B_READ;
            end
         end
         B_READ:  state_in = B_MUL;
         B_MUL:   state_in = B_ADD;
         B_ADD:   state_in = B_ABS;
         B_ABS:   state_in = B_DIV;
         B_DIV: begin
            if (div_cnt_ff == CNT_W'(REM_W - 1)) begin
               state_in = B_FIX;
            end
         end
         B_FIX:   state_in = B_WB;
         B_WB: begin
            wr_en    = 1'b1;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               if (next_result.last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      if (clear.active) begin
         wr_en   = 1'b1;
         wr_addr = clear.addr[SLOT_W-1:0];
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_result_ff <= next_result;
      end
      case (state_ff)
         B_IDLE: begin
            single_ff        <= 1'b1;
            single_status_ff <= STATUS_TRANSPARENT;
            counts_ff        <= pop_entry.counts;
            slot_ff          <= pop_entry.slot[SLOT_W-1:0];
            cwp_ff           <= pop_entry.cw_param;
            ccwp_ff          <= pop_entry.ccw_param;
         end
         B_MUL: begin
            rem_ff     <= $signed(rd_data);
            prod_ff    <= PROD_W'(counts_ff * $signed({1'b0, cfg.taps_per_rev}));
            divisor_ff <= (cfg.rev_counts == '0) ? CPR_W'(1) : cfg.rev_counts;
         end
         B_ADD: begin
            capprod_ff <= CAP_W'(divisor_ff * TAP_W'(MAX_TAPS));
            if (sum_wide[REM_W] != sum_wide[REM_W-1]) begin
               sat_ff <= sum_wide[REM_W] ? REM_MIN : REM_MAX;
            end else begin
               sat_ff <= $signed(sum_wide[REM_W-1:0]);
            end
         end
         B_ABS: begin
            neg_ff     <= sat_ff[REM_W-1];
            mag_ff     <= sat_ff[REM_W-1] ? (~sat_ff + REM_W'(1)) : sat_ff;
            div_q_ff   <= sat_ff[REM_W-1] ? (~sat_ff + REM_W'(1)) : sat_ff;
            div_r_ff   <= '0;
            div_cnt_ff <= '0;
         end
         B_DIV: begin
            div_q_ff   <= {div_q_ff[REM_W-2:0], trial_ge};
            div_r_ff   <= trial_ge ? CPR_W'(trial - {1'b0, divisor_ff}) : trial[CPR_W-1:0];
            div_cnt_ff <= div_cnt_ff + CNT_W'(1);
         end
         B_FIX: begin
            rem_mag_ff <= capped ? (mag_ff - REM_W'(capprod_ff)) : REM_W'(div_r_ff);
            taps_ff    <= capped ? TAP_W'(MAX_TAPS) : div_q_ff[TAP_W-1:0];
         end
         B_WB: begin
            single_ff        <= (taps_ff == '0);
            single_status_ff <= STATUS_OPAQUE;
            press_ff         <= 1'b1;
         end
         B_EMIT: begin
            if (load_out && !single_ff) begin
               press_ff <= !press_ff;
               if (!press_ff) begin
                  taps_ff <= taps_ff - TAP_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   dctd_ram #(
      .WIDTH(REM_W),
      .DEPTH(SLOTS)
   ) u_remainder_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

endmodule

// ===== design/dial_count_to_tap_divider_top.sv =====
// Top level of the dial count to tap divider with its configuration registers.
// A store beat is written when taken; a process beat closes the input until it is queued.
// From an idle back part, a transparent item goes via the queue straight to emit.
// A trigger item runs read, multiply, add, abs, a 48-step shift-subtract divide, fix and
// write-back, then two result beats per tap (one no-tap beat if none), one per cycle unless
// stalled. After reset a clear of all SENSORS*LAYERS slots zeroes both stores; input waits.
`timescale 1ns / 1ps

module dial_count_to_tap_divider_top
   import dctd_pkg::*;
#(
   parameter int SENSORS  = 4,
   parameter int LAYERS   = 8,
   parameter int MAX_TAPS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [1:0]                req_sensor_index,
   input  logic [2:0]                req_layer_index,
   input  logic signed [COUNT_W-1:0] req_dial_counts,
   input  logic                      req_trigger_mode,
   input  logic [PARAM_W-1:0]        req_cw_param,
   input  logic [PARAM_W-1:0]        req_ccw_param,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_direction,
   output logic [PARAM_W-1:0]        rsp_key_param,
   output logic                      rsp_is_press,
   output logic [HOLD_W-1:0]         rsp_hold_ms,
   output logic                      rsp_status,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   logic            push;
   logic            pop;
   queue_entry_type push_entry;
   queue_entry_type pop_entry;
   logic            queue_full;
   logic            queue_empty;
   clear_type       clear;
   result_type      rsp_result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COUNTS_PER_REV:   cfg_in.rev_counts = csr_wdata;
            CSR_TRIGGERS_PER_ROT: cfg_in.taps_per_rev = csr_wdata[TPR_W-1:0];
            CSR_HOLD_TIME:        cfg_in.hold_time_ms = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rev_counts   <= CPR_RESET;
         cfg_ff.taps_per_rev <= TPR_RESET;
         cfg_ff.hold_time_ms <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dctd_front #(
      .SENSORS(SENSORS),
      .LAYERS (LAYERS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_sensor_index (req_sensor_index),
      .req_layer_index  (req_layer_index),
      .req_dial_counts  (req_dial_counts),
      .req_trigger_mode (req_trigger_mode),
      .req_cw_param     (req_cw_param),
      .req_ccw_param    (req_ccw_param),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry),
      .clear            (clear)
   );

   dctd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   dctd_back #(
      .SENSORS (SENSORS),
      .LAYERS  (LAYERS),
      .MAX_TAPS(MAX_TAPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .clear       (clear),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   assign rsp_direction = rsp_result.direction;
   assign rsp_key_param = rsp_result.key_param;
   assign rsp_is_press  = rsp_result.is_press;
   assign rsp_hold_ms   = rsp_result.hold_ms;
   assign rsp_status    = rsp_result.status;
   assign rsp_last      = rsp_result.last;

endmodule

// ===== design/dctd_checker.sv =====
// Port level checks for the dial count to tap divider, bound to the top level.
`timescale 1ns / 1ps

module dctd_checker
   import dctd_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_direction,
   input logic [PARAM_W-1:0]        rsp_key_param,
   input logic                      rsp_is_press,
   input logic [HOLD_W-1:0]         rsp_hold_ms,
   input logic                      rsp_status,
   input logic                      rsp_last
);

   // The clearing pass keeps the input closed on the first cycle after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input open during the clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_direction) &&
      $stable(rsp_key_param) && $stable(rsp_is_press) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // A press is always followed by its release, so it never closes an item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_press |-> !rsp_last && rsp_direction != DIR_NONE &&
      rsp_status == STATUS_OPAQUE)
      else $error("malformed press beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction == DIR_NONE |-> rsp_last && !rsp_is_press &&
      rsp_hold_ms == '0)
      else $error("malformed no-tap beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_TRANSPARENT |-> rsp_direction == DIR_NONE)
      else $error("transparent beat carries a tap");

endmodule

bind dial_count_to_tap_divider_top dctd_checker u_dctd_checker (.*);
